// ===== design/utsu_pkg.sv =====
// Shared constants, types and byte-forming function for the UTF-16 slot to UTF-8 unit.
`default_nettype none
package utsu_pkg;

  // Slot geometry.
  localparam int MAX_SLOT_UNITS = 128;
  localparam int IDX_W          = $clog2(MAX_SLOT_UNITS);
  localparam int ERR_W          = 7;

  // Depth of the job queue between the front and back ends.
  localparam int JQ_DEPTH = 2;
  localparam int JQ_AW    = (JQ_DEPTH > 1) ? $clog2(JQ_DEPTH) : 1;
  localparam int JQ_CW    = $clog2(JQ_DEPTH + 1);

  localparam int CP_W = 21;
  localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;

  // Surrogate prefixes on the upper six bits of a code unit.
  localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
  localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;

  typedef enum logic [2:0] {
    ST_BYTE        = 3'd0,
    ST_TERM        = 3'd1,
    ST_TRUNC_HIGH  = 3'd2,
    ST_MISSING_LOW = 3'd3,
    ST_LONE_LOW    = 3'd4
  } status_t;

  // One job: either a code point to encode or a single status result.
  typedef struct packed {
    status_t          status;
    logic [CP_W-1:0]  cp;
    logic [1:0]       nlast;     // byte count minus one
    logic [ERR_W-1:0] err_idx;
    logic             str_end;   // final result of the job closes the string
  } job_t;

  // Byte k of an (nlast+1)-byte UTF-8 sequence for code point cp.
  function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] cp,
                                           input logic [1:0] nlast,
                                           input logic [1:0] k);
    logic [7:0] b;
    b = 8'h00;
    unique case (nlast)
      2'd0: b = {1'b0, cp[6:0]};
      2'd1: b = (k == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
      2'd2: begin
        unique case (k)
          2'd0:    b = {4'b1110, cp[15:12]};
          2'd1:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      default: begin
        unique case (k)
          2'd0:    b = {5'b11110, cp[20:18]};
          2'd1:    b = {2'b10, cp[17:12]};
          2'd2:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// ===== design/utsu_front.sv =====
// Front end: takes code units, tracks slot and surrogate state, and issues jobs.
`default_nettype none
module utsu_front import utsu_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_take,
  input  wire logic [15:0] code_unit,
  input  wire logic        slot_last,
  output logic             job_push,
  output job_t             job
);

  logic [9:0]       pending_high, pending_high_next;
  logic             pending_valid, pending_valid_next;
  logic [IDX_W-1:0] unit_index, unit_index_next;
  logic             slot_finished, slot_finished_next;

  logic is_high, is_low, last, ended, has_result;
  logic [IDX_W-1:0] prev_index;

  assign is_high    = (code_unit[15:10] == HIGH_SURR_TAG);
  assign is_low     = (code_unit[15:10] == LOW_SURR_TAG);
  assign last       = slot_last | (unit_index == IDX_W'(MAX_SLOT_UNITS - 1));
  assign prev_index = unit_index - IDX_W'(1);

  always_comb begin
    job               = '0;
    job.status        = ST_BYTE;
    has_result        = 1'b0;
    ended             = 1'b0;
    pending_high_next = pending_high;
    pending_valid_next = pending_valid;

    priority if (slot_finished) begin
      has_result = 1'b0;
    end else if (pending_valid) begin
      has_result = 1'b1;
      if (is_low) begin
        job.cp             = SUPP_BASE + CP_W'({pending_high, code_unit[9:0]});
        job.nlast          = 2'd3;
        pending_valid_next = 1'b0;
        pending_high_next  = '0;
      end else begin
        job.status  = ST_MISSING_LOW;
        job.err_idx = ERR_W'(prev_index);
        ended       = 1'b1;
      end
    end else if (code_unit == 16'h0000) begin
      has_result = 1'b1;
      job.status = ST_TERM;
      ended      = 1'b1;
    end else if (is_high) begin
      if (last) begin
        has_result  = 1'b1;
        job.status  = ST_TRUNC_HIGH;
        job.err_idx = ERR_W'(unit_index);
        ended       = 1'b1;
      end else begin
        pending_high_next  = code_unit[9:0];
        pending_valid_next = 1'b1;
      end
    end else if (is_low) begin
      has_result  = 1'b1;
      job.status  = ST_LONE_LOW;
      job.err_idx = ERR_W'(unit_index);
      ended       = 1'b1;
    end else begin
      has_result = 1'b1;
      job.cp     = CP_W'(code_unit);
      priority if (code_unit[15:7] == '0) begin
        job.nlast = 2'd0;
      end else if (code_unit[15:11] == '0) begin
        job.nlast = 2'd1;
      end else begin
        job.nlast = 2'd2;
      end
    end

    job.str_end = ended | last;

    unit_index_next    = unit_index + IDX_W'(1);
    slot_finished_next = slot_finished;
    if (last) begin
      pending_high_next  = '0;
      pending_valid_next = 1'b0;
      unit_index_next    = '0;
      slot_finished_next = 1'b0;
    end else if (ended) begin
      slot_finished_next = 1'b1;
      pending_valid_next = 1'b0;
      pending_high_next  = '0;
    end
  end

  assign job_push = in_take & has_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_high  <= '0;
      pending_valid <= 1'b0;
      unit_index    <= '0;
      slot_finished <= 1'b0;
    end else if (in_take) begin
      pending_high  <= pending_high_next;
      pending_valid <= pending_valid_next;
      unit_index    <= unit_index_next;
      slot_finished <= slot_finished_next;
    end
  end

endmodule
`default_nettype wire

// ===== design/utsu_job_queue.sv =====
// Small register queue of jobs between the front and back ends.
`default_nettype none
module utsu_job_queue import utsu_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_en,
  input  wire job_t wr_job,
  input  wire logic rd_en,
  output job_t      rd_job,
  output logic      q_full,
  output logic      q_valid
);

  job_t             slots [JQ_DEPTH];
  logic [JQ_AW-1:0] wr_ptr, rd_ptr;
  logic [JQ_CW-1:0] count;

  assign q_full  = (count == JQ_CW'(JQ_DEPTH));
  assign q_valid = (count != '0);
  assign rd_job  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == JQ_AW'(JQ_DEPTH - 1)) ? '0 : wr_ptr + JQ_AW'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == JQ_AW'(JQ_DEPTH - 1)) ? '0 : rd_ptr + JQ_AW'(1);
      end
      unique case ({wr_en, rd_en})
        2'b10:   count <= count + JQ_CW'(1);
        2'b01:   count <= count - JQ_CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/utsu_back.sv =====
// Back end: expands each job into result beats held in the output register.
`default_nettype none
module utsu_back import utsu_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  input  wire job_t        q_job,
  output logic             q_take,
  input  wire logic        pop,
  output logic             empty,
  output logic [7:0]       out_byte,
  output logic [2:0]       status,
  output logic             run_last,
  output logic             string_end,
  output logic [ERR_W-1:0] error_unit
);

  logic       out_valid;
  logic [1:0] byte_k;
  logic       load, final_beat, is_byte;

  assign is_byte    = (q_job.status == ST_BYTE);
  assign final_beat = !is_byte || (byte_k == q_job.nlast);
  assign load       = q_valid && (!out_valid || pop);
  assign q_take     = load && final_beat;
  assign empty      = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      byte_k    <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        byte_k    <= final_beat ? 2'd0 : byte_k + 2'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte   <= is_byte ? utf8_byte(q_job.cp, q_job.nlast, byte_k) : 8'h00;
      status     <= q_job.status;
      run_last   <= final_beat;
      string_end <= final_beat && q_job.str_end;
      error_unit <= q_job.err_idx;
    end
  end

endmodule
`default_nettype wire

// ===== design/utf16_slot_to_utf8_unit.sv =====
// Top level of the UTF-16 slot to UTF-8 unit: front end, job queue and back end.
//
// This unit reads a text slot one little-endian UTF-16 code unit per beat,
// with slot_last marking the slot's final unit (the unit at index
// MAX_SLOT_UNITS-1 counts as final on its own), and delivers the UTF-8 form
// of the string one result beat at a time. A result beat carries either a
// UTF-8 byte (status 0) or a single status: terminator seen, truncated high
// surrogate, high surrogate without low, or lone low surrogate; the error
// statuses report the slot index of the faulting unit in error_unit.
// run_last flags the final beat caused by one input unit and string_end
// flags the beat that completes the string. After a terminator or an error
// the rest of the slot gives no results, and all state returns to its reset
// value once the slot's last unit has been taken. Both sides behave as
// queues: a unit is taken on a clock edge with push high and full low, and
// the oldest result is taken on an edge with pop high and empty low. The
// front end takes one unit per cycle while its two-entry job queue has
// room; the back end's output register emits one byte per cycle while
// jobs are queued and results are popped. A unit yields one byte for
// ASCII, two or three for other BMP characters, four for a surrogate
// pair (two bytes per unit on average), or one status beat. Units that
// yield nothing, such as a held high surrogate or units after the
// string's end, are taken without adding a job. A result passes through
// the job queue and then the output register to reach the output ports.
`default_nettype none
module utf16_slot_to_utf8_unit import utsu_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [15:0] code_unit,
  input  wire logic        slot_last,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_byte,
  output logic [2:0]       status,
  output logic             run_last,
  output logic             string_end,
  output logic [6:0]       error_unit
);

  // The front end may take a unit whenever the job queue has room, even if
  // the unit turns out to yield no job.
  logic in_take;
  logic job_push;
  job_t front_job;
  job_t head_job;
  logic q_full, q_valid, q_take;

  assign full    = q_full;
  assign in_take = push && !q_full;

  utsu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_take   (in_take),
    .code_unit (code_unit),
    .slot_last (slot_last),
    .job_push  (job_push),
    .job       (front_job)
  );

  // Jobs wait here so the front end keeps taking units while a multi-byte
  // sequence drains from the back end.
  utsu_job_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_push),
    .wr_job  (front_job),
    .rd_en   (q_take),
    .rd_job  (head_job),
    .q_full  (q_full),
    .q_valid (q_valid)
  );

  // The back end reloads its output register in the same cycle the current
  // beat is popped, so bytes stream at one per cycle while jobs are queued.
  utsu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_job      (head_job),
    .q_take     (q_take),
    .pop        (pop),
    .empty      (empty),
    .out_byte   (out_byte),
    .status     (status),
    .run_last   (run_last),
    .string_end (string_end),
    .error_unit (error_unit)
  );

endmodule
`default_nettype wire

// ===== design/utsu_checker.sv =====
// Port-level checks for the UTF-16 slot to UTF-8 unit and their binding.
`default_nettype none
module utsu_checker import utsu_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] out_byte,
  input wire logic [2:0] status,
  input wire logic       run_last,
  input wire logic       string_end,
  input wire logic [6:0] error_unit
);

  // Nothing is offered in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result offered right after reset");

  // A waiting beat that is not taken stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(status)
                          && $stable(run_last) && $stable(string_end)))
    else $error("waiting result changed before pop");

  // A status beat is always the only and final beat of its unit and string.
  a_status_closes: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != ST_BYTE) |-> (run_last && string_end && out_byte == 8'h00))
    else $error("status beat without run_last and string_end");

  // The string ends only on the last beat of a unit.
  a_end_on_run_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && string_end) |-> run_last)
    else $error("string_end on a beat that is not run_last");

  // Only error statuses carry a unit index.
  a_err_idx: assert property (@(posedge clk) disable iff (rst)
    (!empty && (status == ST_BYTE || status == ST_TERM)) |-> (error_unit == 7'd0))
    else $error("error_unit set on a non-error beat");

endmodule

bind utf16_slot_to_utf8_unit utsu_checker u_utsu_checker (
  .clk        (clk),
  .rst        (rst),
  .empty      (empty),
  .pop        (pop),
  .out_byte   (out_byte),
  .status     (status),
  .run_last   (run_last),
  .string_end (string_end),
  .error_unit (error_unit)
);
`default_nettype wire
